>>> rtl/response_frame_deframer_top_defines.svh
// Assertion macros for the response frame deframer.
// Included by the top level; no other dependencies.
`ifndef RESPONSE_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define RESPONSE_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, disabled during reset
`define RFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

>>> rtl/rfd_pkg.sv
// Shared types and constants for the response frame deframer.
// No dependencies; imported by every module of the block.
package rfd_pkg;

  localparam logic [7:0]  SYNC_FIRST    = 8'h55;
  localparam logic [7:0]  SYNC_SECOND   = 8'hAA;
  localparam int          HDR_BYTES     = 6;
  localparam int          HDR_IDX_W     = $clog2(HDR_BYTES);
  localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

  // Receive phase
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_GOT_FIRST,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  // One result item
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic        frame_ok;
    logic [15:0] sequence_number;
    logic [7:0]  command_code;
    logic [7:0]  status_code;
    logic [15:0] payload_length;
  } res_t;

endpackage

>>> rtl/rfd_core.sv
// Deframer state machine: sync hunt, header capture, resync, payload, checksum.
// Depends on rfd_pkg.
module rfd_core
  import rfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        accept,
  input  logic [7:0]  rx_byte,
  output logic        res_push,
  output res_t        res
);

  phase_t              phase_r, phase_nxt;
  logic [HDR_IDX_W-1:0] count_r, count_nxt;
  logic [15:0]         rem_r, rem_nxt;
  logic [7:0]          xor_r, xor_nxt;
  logic [15:0]         max_len_r;
  logic [7:0]          store_r   [HDR_BYTES];
  logic [7:0]          store_nxt [HDR_BYTES];

  // Rescan of the held header bytes
  logic [7:0]           held     [HDR_BYTES];
  logic                 rs_found;
  logic [HDR_IDX_W-1:0] rs_pos;
  logic [7:0]           rs_store [HDR_BYTES-2];
  logic [HDR_IDX_W-1:0] rs_count;
  logic [7:0]           rs_xor;
  logic [15:0]          hdr_len;

  assign hdr_len = {store_r[4], rx_byte};

  // Held bytes: five stored plus the one arriving now
  always_comb begin
    for (int i = 0; i < HDR_BYTES - 1; i++) held[i] = store_r[i];
    held[HDR_BYTES-1] = rx_byte;
  end

  // First sync pair inside the held bytes, and the partial header after it
  always_comb begin
    logic [HDR_IDX_W:0] idx;
    rs_found = 1'b0;
    rs_pos   = '0;
    for (int p = 0; p < HDR_BYTES - 1; p++) begin
      if (!rs_found && held[p] == SYNC_FIRST && held[p+1] == SYNC_SECOND) begin
        rs_found = 1'b1;
        rs_pos   = HDR_IDX_W'(p);
      end
    end
    rs_xor = SYNC_FIRST ^ SYNC_SECOND;
    for (int i = 0; i < HDR_BYTES; i++) begin
      if (HDR_IDX_W'(i) >= rs_pos + HDR_IDX_W'(2)) rs_xor = rs_xor ^ held[i];
    end
    for (int j = 0; j < HDR_BYTES - 2; j++) begin
      idx = {1'b0, rs_pos} + (HDR_IDX_W+1)'(j + 2);
      if (idx < (HDR_IDX_W+1)'(HDR_BYTES)) rs_store[j] = held[idx[HDR_IDX_W-1:0]];
      else rs_store[j] = store_r[j];
    end
    rs_count = HDR_IDX_W'(HDR_BYTES - 2) - rs_pos;
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    xor_nxt   = xor_r;
    for (int i = 0; i < HDR_BYTES; i++) store_nxt[i] = store_r[i];
    if (accept) begin
      case (phase_r)
        PH_GOT_FIRST: begin
          if (rx_byte == SYNC_SECOND) begin
            phase_nxt = PH_HEADER;
            count_nxt = '0;
            xor_nxt   = SYNC_FIRST ^ SYNC_SECOND;
          end else if (rx_byte != SYNC_FIRST) begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_HEADER: begin
          for (int i = 0; i < HDR_BYTES; i++) begin
            if (count_r == HDR_IDX_W'(i)) store_nxt[i] = rx_byte;
          end
          xor_nxt = xor_r ^ rx_byte;
          if (count_r == HDR_IDX_W'(HDR_BYTES - 1)) begin
            count_nxt = '0;
            if (hdr_len > max_len_r) begin
              if (rs_found) begin
                for (int j = 0; j < HDR_BYTES - 2; j++) store_nxt[j] = rs_store[j];
                count_nxt = rs_count;
                xor_nxt   = rs_xor;
                phase_nxt = PH_HEADER;
              end else begin
                xor_nxt   = '0;
                phase_nxt = (rx_byte == SYNC_FIRST) ? PH_GOT_FIRST : PH_HUNT;
              end
            end else begin
              rem_nxt   = hdr_len;
              phase_nxt = (hdr_len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
            end
          end else begin
            count_nxt = count_r + HDR_IDX_W'(1);
          end
        end
        PH_PAYLOAD: begin
          xor_nxt = xor_r ^ rx_byte;
          rem_nxt = rem_r - 16'd1;
          if (rem_nxt == 16'd0) phase_nxt = PH_CHECK;
        end
        PH_CHECK: begin
          phase_nxt = PH_HUNT;
          xor_nxt   = '0;
          rem_nxt   = '0;
        end
        default: begin
          phase_nxt = (rx_byte == SYNC_FIRST) ? PH_GOT_FIRST : PH_HUNT;
        end
      endcase
    end
  end

  // Result for the item being accepted
  always_comb begin
    res.payload_valid   = (phase_r == PH_PAYLOAD);
    res.payload_byte    = (phase_r == PH_PAYLOAD) ? rx_byte : 8'd0;
    res.frame_end       = (phase_r == PH_CHECK);
    res.frame_ok        = (phase_r == PH_CHECK) && (xor_r == rx_byte);
    res.sequence_number = {store_r[0], store_r[1]};
    res.command_code    = store_r[2];
    res.status_code     = store_r[3];
    res.payload_length  = {store_r[4], store_r[5]};
    res_push            = accept && (phase_r == PH_PAYLOAD || phase_r == PH_CHECK);
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      count_r   <= '0;
      rem_r     <= '0;
      xor_r     <= '0;
      max_len_r <= MAX_LEN_RESET;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      xor_r   <= xor_nxt;
      if (cfg_wr_en) max_len_r <= cfg_wr_data;
    end
  end

  // Header bytes, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < HDR_BYTES; i++) store_r[i] <= store_nxt[i];
  end

endmodule

>>> rtl/rfd_skid.sv
// Two-entry output buffer: result register plus skid register.
// Depends on rfd_pkg for the result type.
module rfd_skid
  import rfd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic push_ready,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_data_r, out_data_nxt;
  res_t skid_data_r, skid_data_nxt;
  logic pop;

  assign pop        = out_valid_r && out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // Buffer movement
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

>>> rtl/response_frame_deframer_top.sv
// Response frame deframer top level: core state machine and output buffer.
// Depends on rfd_pkg, rfd_core, rfd_skid and the assertion macro header.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   in_rx_byte
//   out      out_valid / out_ready out_payload_*, out_frame_*, header fields
//   cfg      cfg_wr_en             cfg_wr_data (max payload length)
//
// One byte is accepted per cycle while in_ready is high; each result is formed
// combinationally and registered into the output register or the skid register.
// Sync reset clears the phase, counters and checksum; max length resets to 4096.
// A stalled result moves to the skid register; input stalls only when both
// output entries are full.
`include "response_frame_deframer_top_defines.svh"
module response_frame_deframer_top
  import rfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic        out_frame_end,
  output logic        out_frame_ok,
  output logic [15:0] out_sequence_number,
  output logic [7:0]  out_command_code,
  output logic [7:0]  out_status_code,
  output logic [15:0] out_payload_length,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic accept;
  logic res_push;
  res_t res;
  res_t out_data;

  assign accept = in_valid && in_ready;

  rfd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .rx_byte     (in_rx_byte),
    .res_push    (res_push),
    .res         (res)
  );

  rfd_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_push),
    .push_data  (res),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_payload_valid   = out_data.payload_valid;
  assign out_payload_byte    = out_data.payload_byte;
  assign out_frame_end       = out_data.frame_end;
  assign out_frame_ok        = out_data.frame_ok;
  assign out_sequence_number = out_data.sequence_number;
  assign out_command_code    = out_data.command_code;
  assign out_status_code     = out_data.status_code;
  assign out_payload_length  = out_data.payload_length;

  // Checks
  `RFD_ASSERT_NEXT(a_skid_fill, clk, rst_n, res_push && out_valid && !out_ready, !in_ready)
  `RFD_ASSERT_IMPL(a_ok_at_end, clk, rst_n, out_valid && out_frame_ok, out_frame_end)
  `RFD_ASSERT_IMPL(a_payload_len, clk, rst_n, out_valid && out_payload_valid, out_payload_length != 16'd0)

endmodule

>>> tb/sv/tb_response_frame_deframer_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for response_frame_deframer_top: byte stream in, checked results out.
// Depends on rfd_pkg and the deframer RTL; a built-in deframer model predicts each result.
module tb_response_frame_deframer_top;
  import rfd_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int RANDOM_ITEMS = 200;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_payload_valid;
  logic [7:0]  out_payload_byte;
  logic        out_frame_end;
  logic        out_frame_ok;
  logic [15:0] out_sequence_number;
  logic [7:0]  out_command_code;
  logic [7:0]  out_status_code;
  logic [15:0] out_payload_length;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;

  // Bytes waiting to be sent and results waiting to be seen
  logic [7:0] tx_bytes [$];
  res_t       pending_results [$];
  res_t       want_res;

  // Deframer model state
  phase_t      m_phase;
  logic [7:0]  m_hdr [HDR_BYTES];
  int          m_hcnt;
  logic [15:0] m_remain;
  logic [7:0]  m_xor;
  logic [15:0] len_limit;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int queued_items = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int frames_ended = 0;
  int frames_good = 0;
  int error_count = 0;

  response_frame_deframer_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_payload_valid   (out_payload_valid),
    .out_payload_byte    (out_payload_byte),
    .out_frame_end       (out_frame_end),
    .out_frame_ok        (out_frame_ok),
    .out_sequence_number (out_sequence_number),
    .out_command_code    (out_command_code),
    .out_status_code     (out_status_code),
    .out_payload_length  (out_payload_length),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Advance the deframer model by one byte; returns 1 when the byte yields a result
  function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
    logic [7:0]  held [HDR_BYTES];
    logic [15:0] len;
    bit          found;
    bit          has_res;
    int          p;
    int          i;
    r = '0;
    has_res = 1'b0;
    case (m_phase)
      PH_GOT_FIRST: begin
        if (b == SYNC_SECOND) begin
          m_phase = PH_HEADER;
          m_hcnt = 0;
          m_xor = SYNC_FIRST ^ SYNC_SECOND;
        end else if (b != SYNC_FIRST) begin
          m_phase = PH_HUNT;
        end
      end
      PH_HEADER: begin
        m_hdr[m_hcnt] = b;
        m_hcnt++;
        m_xor ^= b;
        if (m_hcnt == HDR_BYTES) begin
          len = {m_hdr[4], m_hdr[5]};
          m_hcnt = 0;
          if (len > len_limit) begin
            // Length too long: look for a new sync pair inside the held header
            held = m_hdr;
            found = 1'b0;
            for (p = 0; p < HDR_BYTES - 1; p++) begin
              if (!found && held[p] == SYNC_FIRST && held[p + 1] == SYNC_SECOND) begin
                found = 1'b1;
                m_xor = SYNC_FIRST ^ SYNC_SECOND;
                for (i = p + 2; i < HDR_BYTES; i++) begin
                  m_hdr[m_hcnt] = held[i];
                  m_xor ^= held[i];
                  m_hcnt++;
                end
                m_phase = PH_HEADER;
              end
            end
            if (!found) begin
              m_hcnt = 0;
              m_xor = 8'h00;
              m_phase = (held[HDR_BYTES - 1] == SYNC_FIRST) ? PH_GOT_FIRST : PH_HUNT;
            end
          end else begin
            m_remain = len;
            m_phase = (len == 16'd0) ? PH_CHECK : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        m_xor ^= b;
        m_remain--;
        if (m_remain == 16'd0) m_phase = PH_CHECK;
        r.payload_valid = 1'b1;
        r.payload_byte = b;
        has_res = 1'b1;
      end
      PH_CHECK: begin
        r.frame_end = 1'b1;
        r.frame_ok = (m_xor == b);
        m_phase = PH_HUNT;
        m_xor = 8'h00;
        m_remain = 16'd0;
        has_res = 1'b1;
      end
      default: begin
        m_phase = (b == SYNC_FIRST) ? PH_GOT_FIRST : PH_HUNT;
      end
    endcase
    if (has_res) begin
      r.sequence_number = {m_hdr[0], m_hdr[1]};
      r.command_code = m_hdr[2];
      r.status_code = m_hdr[3];
      r.payload_length = {m_hdr[4], m_hdr[5]};
    end
    return has_res;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  // Input driver: presents queued bytes, predicts the result of each accepted item
  always @(posedge clk) begin
    res_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        bytes_sent++;
        if (deframe_byte(in_rx_byte, r)) pending_results.push_back(r);
      end
      if (!(in_valid && !in_ready)) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= tx_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random backpressure, compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result item with none expected");
          error_count++;
        end else begin
          want_res = pending_results.pop_front();
          if (want_res.frame_end) begin
            frames_ended++;
            if (want_res.frame_ok) frames_good++;
          end
          check_field("payload_valid", 16'(want_res.payload_valid), 16'(out_payload_valid));
          check_field("payload_byte", 16'(want_res.payload_byte), 16'(out_payload_byte));
          check_field("frame_end", 16'(want_res.frame_end), 16'(out_frame_end));
          check_field("frame_ok", 16'(want_res.frame_ok), 16'(out_frame_ok));
          check_field("sequence_number", want_res.sequence_number, out_sequence_number);
          check_field("command_code", 16'(want_res.command_code), 16'(out_command_code));
          check_field("status_code", 16'(want_res.status_code), 16'(out_status_code));
          check_field("payload_length", want_res.payload_length, out_payload_length);
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b, input bit counted);
    tx_bytes.push_back(b);
    if (counted) queued_items++;
  endtask

  // Sync pair and header; payload and checksum follow only when the length fits
  task automatic push_frame(input logic [47:0] hdr, input bit good_sum);
    logic [7:0] sum;
    logic [7:0] b;
    int         k;
    int         sel;
    sum = SYNC_FIRST ^ SYNC_SECOND;
    push_byte(SYNC_FIRST, 1'b1);
    push_byte(SYNC_SECOND, 1'b1);
    for (k = 0; k < HDR_BYTES; k++) begin
      b = hdr[47 - 8 * k -: 8];
      sum ^= b;
      push_byte(b, 1'b1);
    end
    if (hdr[15:0] <= len_limit) begin
      for (k = 0; k < hdr[15:0]; k++) begin
        sel = $urandom_range(9);
        b = (sel == 0) ? SYNC_FIRST : (sel == 1) ? SYNC_SECOND : 8'($urandom_range(255));
        sum ^= b;
        push_byte(b, 1'b1);
      end
      push_byte(good_sum ? sum : sum ^ 8'($urandom_range(255, 1)), 1'b1);
    end
  endtask

  // Mostly short payloads, with zero and the limit itself when it is small
  function automatic logic [15:0] pick_len();
    int sel;
    sel = $urandom_range(99);
    if (len_limit == 16'd0 || sel < 10) return 16'd0;
    if (sel < 25 && len_limit <= 16'd40) return len_limit;
    return 16'($urandom_range((len_limit < 16'd12) ? int'(len_limit) : 12, 1));
  endfunction

  task automatic random_traffic(input int n);
    logic [47:0] hdr;
    int          start_cnt;
    int          kind;
    int          sel;
    int          k;
    int          cnt;
    start_cnt = queued_items;
    while (queued_items - start_cnt < n) begin
      kind = $urandom_range(99);
      if (kind < 70 || (kind < 82 && len_limit == 16'hFFFF)) begin
        hdr[47:16] = $urandom;
        hdr[15:0] = pick_len();
        push_frame(hdr, $urandom_range(3) != 0);
      end else if (kind < 82) begin
        // Oversized length, sometimes with a sync pair or a trailing first sync byte
        hdr[47:16] = $urandom;
        hdr[15:0] = 16'($urandom_range(65535, int'(len_limit) + 1));
        sel = $urandom_range(9);
        if (sel < 4) begin
          k = $urandom_range(2);
          hdr[47 - 8 * k -: 16] = {SYNC_FIRST, SYNC_SECOND};
        end else if (sel < 6) begin
          hdr[7:0] = SYNC_FIRST;
          if (hdr[15:0] <= len_limit) hdr[15:8] = 8'hFF;
        end
        push_frame(hdr, 1'b1);
      end else if (kind < 90) begin
        // Frame cut short inside the header
        push_byte(SYNC_FIRST, 1'b1);
        push_byte(SYNC_SECOND, 1'b1);
        cnt = $urandom_range(HDR_BYTES - 1);
        for (k = 0; k < cnt; k++) push_byte(8'($urandom_range(255)), 1'b1);
      end else begin
        // Line noise
        cnt = $urandom_range(4, 1);
        for (k = 0; k < cnt; k++) begin
          sel = $urandom_range(9);
          push_byte((sel < 3) ? SYNC_FIRST : (sel < 5) ? SYNC_SECOND : 8'($urandom_range(255)),
                    1'b0);
        end
      end
    end
  endtask

  // Hold off until every queued byte is sent and every result has come back
  task automatic drain();
    do @(posedge clk);
    while (tx_bytes.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_len_limit(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    len_limit = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Main sequence: directed frames, then random traffic under several limits and loads
  initial begin
    logic [7:0] sum;
    logic [7:0] dir_bytes [$];
    int         k;
    m_phase = PH_HUNT;
    for (k = 0; k < HDR_BYTES; k++) m_hdr[k] = 8'h00;
    m_hcnt = 0;
    m_remain = 16'd0;
    m_xor = 8'h00;
    len_limit = MAX_LEN_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Repeated first sync byte, then an all-zero header with zero length
    push_byte(SYNC_FIRST, 1'b1);
    push_frame(48'h0, 1'b1);
    // Oversized length with a sync pair up front: rescan leaves an all-ones partial
    // header, which then gets length 1, payload 0xFF and a bad checksum
    dir_bytes = '{SYNC_FIRST, SYNC_SECOND, SYNC_FIRST, SYNC_SECOND, 8'hFF, 8'hFF,
                  8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFF};
    sum = SYNC_FIRST ^ SYNC_SECOND;
    for (k = 0; k < dir_bytes.size(); k++) begin
      push_byte(dir_bytes[k], 1'b1);
      if (k >= 4) sum ^= dir_bytes[k];
    end
    push_byte(sum ^ 8'h80, 1'b1);
    drain();

    write_len_limit(16'd16);
    random_traffic(RANDOM_ITEMS);
    drain();

    send_idle_pct = 69;
    write_len_limit(16'd0);
    random_traffic(RANDOM_ITEMS);
    drain();

    send_idle_pct = 0;
    stall_pct = 69;
    write_len_limit(16'hFFFF);
    random_traffic(RANDOM_ITEMS);
    drain();

    send_idle_pct = 18;
    stall_pct = 18;
    write_len_limit(16'd5);
    random_traffic(RANDOM_ITEMS);
    drain();

    $display("Sent %0d bytes, checked %0d results, %0d frame ends (%0d with good checksum)",
             bytes_sent, results_seen, frames_ended, frames_good);
    $display("Length limits 4096, 16, 0, 65535 and 5 under four sender/receiver load mixes");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/rfd_pkg.sv
rtl/rfd_core.sv
rtl/rfd_skid.sv
rtl/response_frame_deframer_top.sv
tb/sv/tb_response_frame_deframer_top.sv
